// ===== hw/rtl/rhs_pkg.sv =====
// ----------------------------------------------------------------------------
// rhs_pkg
// shared types and codes of the rgb histogram and statistics core
// ----------------------------------------------------------------------------
`default_nettype none

package rhs_pkg;

	// item kinds carried on the input tuser
	localparam logic [1:0] KIND_START    = 2'd0;
	localparam logic [1:0] KIND_PIXEL    = 2'd1;
	localparam logic [1:0] KIND_READ_BIN = 2'd2;
	localparam logic [1:0] KIND_READ_SUM = 2'd3;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BITS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_USE_MASK   = 2'd1;

	// channel select codes of a summary read
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// channel depth and counter width, fixed by the stream field widths
	localparam int MAX_BITS   = 12;
	localparam int COUNT_BITS = 24;

	localparam int NUM_CH     = 3;
	localparam int SUM_W      = 36;
	localparam int DEPTH_W    = 5;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 160;

	typedef struct packed {
		logic [4:0]  pad;
		logic [1:0]  channel;
		logic [11:0] bin_index;
		logic        mask_bit;
		logic [11:0] blue;
		logic [11:0] green;
		logic [11:0] red;
	} in_data_t;

	typedef struct packed {
		logic [2:0]       pad;
		logic [23:0]      pixels_counted;
		logic [SUM_W-1:0] channel_sum;
		logic [11:0]      channel_max;
		logic [12:0]      channel_min;
		logic [23:0]      blue_count;
		logic [23:0]      green_count;
		logic [23:0]      red_count;
	} out_data_t;

	// control of one histogram bank
	typedef struct packed {
		logic acc;
		logic inc;
		logic clr;
	} bank_ctl_t;

	// control of the statistics registers
	typedef struct packed {
		logic clr;
		logic take;
	} stats_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rhs_hist_bank.sv =====
// ----------------------------------------------------------------------------
// rhs_hist_bank
// one histogram memory with saturating read-modify-write and forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module rhs_hist_bank #(
	parameter int IDX_W = 12,
	parameter int CNT_W = 24
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  rhs_pkg::bank_ctl_t    ctl,
	input  wire  [IDX_W-1:0]      acc_addr,
	input  wire  [IDX_W-1:0]      clr_addr,
	output logic [CNT_W-1:0]      count
);
	import rhs_pkg::*;

	logic [CNT_W-1:0] mem [2**IDX_W];

	logic [CNT_W-1:0] rdata_s1;
	logic [CNT_W-1:0] fwd_data_s1;
	logic             fwd_s1;
	logic             inc_s1;
	logic [IDX_W-1:0] addr_s1;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [CNT_W-1:0] wr_data;
	logic [CNT_W-1:0] cur;

	assign cur   = fwd_s1 ? fwd_data_s1 : rdata_s1;
	assign count = cur;

	always_comb begin
		if (ctl.clr) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr;
			wr_data = '0;
		end else begin
			wr_en   = inc_s1;
			wr_addr = addr_s1;
			wr_data = (&cur) ? cur : cur + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.acc) begin
			rdata_s1 <= mem[acc_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			addr_s1     <= acc_addr;
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (ctl.acc) begin
			inc_s1 <= ctl.inc;
			fwd_s1 <= wr_en && (wr_addr == acc_addr);
		end else begin
			inc_s1 <= 1'b0;
		end
	end

	a_no_update_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |-> !inc_s1)
		else $error("bin update collides with clear pass");

	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |-> !ctl.acc)
		else $error("bin access during clear pass");

	a_single_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		(inc_s1 && !ctl.acc) |=> !inc_s1)
		else $error("bin written back twice");

endmodule

`default_nettype wire

// ===== hw/rtl/rhs_stats.sv =====
// ----------------------------------------------------------------------------
// rhs_stats
// per-channel minimum, maximum, saturating sum and included pixel count
// ----------------------------------------------------------------------------
`default_nettype none

module rhs_stats #(
	parameter int MAX_BITS   = 12,
	parameter int COUNT_BITS = 24
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  rhs_pkg::stats_ctl_t        ctl,
	input  wire  [MAX_BITS:0]          min_init,
	input  wire  [MAX_BITS-1:0]        red,
	input  wire  [MAX_BITS-1:0]        green,
	input  wire  [MAX_BITS-1:0]        blue,
	input  wire  [1:0]                 sel,
	output logic [MAX_BITS:0]          sel_min,
	output logic [MAX_BITS-1:0]        sel_max,
	output logic [rhs_pkg::SUM_W-1:0]  sel_sum,
	output logic [COUNT_BITS-1:0]      count
);
	import rhs_pkg::*;

	localparam int MIN_W = MAX_BITS + 1;
	localparam int RESET_DEPTH = (MAX_BITS < 8) ? MAX_BITS : 8;
	localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(1) << RESET_DEPTH;

	logic [MIN_W-1:0]    low_q  [NUM_CH];
	logic [MAX_BITS-1:0] high_q [NUM_CH];
	logic [SUM_W-1:0]    sum_q  [NUM_CH];
	logic [COUNT_BITS-1:0] count_q;

	logic [MAX_BITS-1:0] v [NUM_CH];
	logic [SUM_W:0]      sum_add [NUM_CH];

	assign v[0] = red;
	assign v[1] = green;
	assign v[2] = blue;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum_add[c] = {1'b0, sum_q[c]} + (SUM_W+1)'(v[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				low_q[c]  <= MIN_RESET;
				high_q[c] <= '0;
				sum_q[c]  <= '0;
			end
			count_q <= '0;
		end else if (ctl.clr) begin
			for (int c = 0; c < NUM_CH; c++) begin
				low_q[c]  <= min_init;
				high_q[c] <= '0;
				sum_q[c]  <= '0;
			end
			count_q <= '0;
		end else if (ctl.take) begin
			for (int c = 0; c < NUM_CH; c++) begin
				if ({1'b0, v[c]} < low_q[c]) begin
					low_q[c] <= {1'b0, v[c]};
				end
				if (v[c] > high_q[c]) begin
					high_q[c] <= v[c];
				end
				sum_q[c] <= sum_add[c][SUM_W] ? '1 : sum_add[c][SUM_W-1:0];
			end
			if (!(&count_q)) begin
				count_q <= count_q + COUNT_BITS'(1);
			end
		end
	end

	always_comb begin
		unique case (sel)
			CH_RED: begin
				sel_min = low_q[0];
				sel_max = high_q[0];
				sel_sum = sum_q[0];
			end
			CH_GREEN: begin
				sel_min = low_q[1];
				sel_max = high_q[1];
				sel_sum = sum_q[1];
			end
			CH_BLUE: begin
				sel_min = low_q[2];
				sel_max = high_q[2];
				sel_sum = sum_q[2];
			end
			default: begin
				sel_min = '0;
				sel_max = '0;
				sel_sum = '0;
			end
		endcase
	end

	assign count = count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_histogram_with_stats_core.sv =====
// ----------------------------------------------------------------------------
// rgb_histogram_with_stats_core
// rgb histograms with per-channel min, max, sum and pixel count
// ----------------------------------------------------------------------------
// Pixels, bin reads and summary reads are taken at one per clock while
// no clear pass runs and no read result is stalled: each histogram is a
// single-port-write memory updated by a registered read, then an
// increment and write back, with the newest write forwarded to a following
// access of the same bin. A read result is registered in the read stage
// and then in an output register, where it waits. A start item, and reset,
// run a clear pass that writes zero to every bin, one bin per cycle; no
// item is taken during it, while configuration writes are always taken.
`default_nettype none

module rgb_histogram_with_stats_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// red, green, blue, mask_bit, bin_index, channel, zero pad
	input  wire  [rhs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// kind
	input  wire  [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// red_count, green_count, blue_count, channel_min, channel_max,
	// channel_sum, pixels_counted, zero pad
	output logic [rhs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [rhs_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire  [rhs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import rhs_pkg::*;

	localparam int IDX_W = MAX_BITS;
	localparam int MIN_W = MAX_BITS + 1;

	in_data_t  din;
	out_data_t dout;

	logic [3:0]         pixel_bits_q;
	logic               use_mask_q;
	logic [DEPTH_W-1:0] depth;
	logic [IDX_W-1:0]   vmask;
	logic [MIN_W-1:0]   min_init;

	logic [IDX_W-1:0] red_m;
	logic [IDX_W-1:0] green_m;
	logic [IDX_W-1:0] blue_m;
	logic [IDX_W-1:0] bin_m;

	logic in_acc;
	logic is_start;
	logic include_px;
	logic is_read;

	logic             clearing_q;
	logic [IDX_W-1:0] clr_addr_q;

	logic s1_valid_q;
	logic s1_bin_s1;
	logic [MIN_W-1:0]      s1_min_s1;
	logic [MAX_BITS-1:0]   s1_max_s1;
	logic [SUM_W-1:0]      s1_sum_s1;
	logic [COUNT_BITS-1:0] s1_cnt_s1;
	logic out_free;
	logic s1_move;

	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  m_valid_q;

	bank_ctl_t  bank_ctl;
	stats_ctl_t stats_ctl;
	logic [IDX_W-1:0] acc_addr_r;
	logic [IDX_W-1:0] acc_addr_g;
	logic [IDX_W-1:0] acc_addr_b;
	logic [COUNT_BITS-1:0] cnt_r;
	logic [COUNT_BITS-1:0] cnt_g;
	logic [COUNT_BITS-1:0] cnt_b;

	logic [MIN_W-1:0]      st_min;
	logic [MAX_BITS-1:0]   st_max;
	logic [SUM_W-1:0]      st_sum;
	logic [COUNT_BITS-1:0] st_cnt;

	assign din = s_axis_tdata;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bits_q <= 4'd8;
			use_mask_q   <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_PIXEL_BITS) begin
				pixel_bits_q <= cfg_data[3:0];
			end else if (cfg_index == REG_USE_MASK) begin
				use_mask_q <= cfg_data[0];
			end
		end
	end

	always_comb begin
		priority if (pixel_bits_q == 4'd0) begin
			depth = DEPTH_W'(1);
		end else if (DEPTH_W'(pixel_bits_q) > DEPTH_W'(MAX_BITS)) begin
			depth = DEPTH_W'(MAX_BITS);
		end else begin
			depth = DEPTH_W'(pixel_bits_q);
		end
	end

	assign vmask    = ~({IDX_W{1'b1}} << depth);
	assign min_init = MIN_W'(1) << depth;

	assign red_m   = IDX_W'(din.red) & vmask;
	assign green_m = IDX_W'(din.green) & vmask;
	assign blue_m  = IDX_W'(din.blue) & vmask;
	assign bin_m   = IDX_W'(din.bin_index) & vmask;

	// input side
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s1_move       = s1_valid_q && out_free;
	assign s_axis_tready = !clearing_q && (!s1_valid_q || out_free);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_start      = in_acc && (s_axis_tuser == KIND_START);
	assign include_px    = in_acc && (s_axis_tuser == KIND_PIXEL) &&
		(!use_mask_q || din.mask_bit);
	assign is_read       = in_acc &&
		((s_axis_tuser == KIND_READ_BIN) || (s_axis_tuser == KIND_READ_SUM));

	// clear pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (is_start) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// histogram banks
	assign bank_ctl.acc = include_px ||
		(in_acc && (s_axis_tuser == KIND_READ_BIN));
	assign bank_ctl.inc = include_px;
	assign bank_ctl.clr = clearing_q;

	assign acc_addr_r = include_px ? red_m : bin_m;
	assign acc_addr_g = include_px ? green_m : bin_m;
	assign acc_addr_b = include_px ? blue_m : bin_m;

	rhs_hist_bank #(.IDX_W(IDX_W), .CNT_W(COUNT_BITS)) u_bank_red (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (bank_ctl),
		.acc_addr (acc_addr_r),
		.clr_addr (clr_addr_q),
		.count    (cnt_r)
	);

	rhs_hist_bank #(.IDX_W(IDX_W), .CNT_W(COUNT_BITS)) u_bank_green (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (bank_ctl),
		.acc_addr (acc_addr_g),
		.clr_addr (clr_addr_q),
		.count    (cnt_g)
	);

	rhs_hist_bank #(.IDX_W(IDX_W), .CNT_W(COUNT_BITS)) u_bank_blue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (bank_ctl),
		.acc_addr (acc_addr_b),
		.clr_addr (clr_addr_q),
		.count    (cnt_b)
	);

	// statistics
	assign stats_ctl.clr  = is_start;
	assign stats_ctl.take = include_px;

	rhs_stats #(.MAX_BITS(MAX_BITS), .COUNT_BITS(COUNT_BITS)) u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (stats_ctl),
		.min_init (min_init),
		.red      (red_m),
		.green    (green_m),
		.blue     (blue_m),
		.sel      (din.channel),
		.sel_min  (st_min),
		.sel_max  (st_max),
		.sel_sum  (st_sum),
		.count    (st_cnt)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= is_read;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_read) begin
			s1_bin_s1 <= (s_axis_tuser == KIND_READ_BIN);
			s1_min_s1 <= st_min;
			s1_max_s1 <= st_max;
			s1_sum_s1 <= st_sum;
			s1_cnt_s1 <= st_cnt;
		end
	end

	always_comb begin
		dout = '0;
		if (s1_bin_s1) begin
			dout.red_count   = cnt_r;
			dout.green_count = cnt_g;
			dout.blue_count  = cnt_b;
		end else begin
			dout.channel_min    = s1_min_s1;
			dout.channel_max    = s1_max_s1;
			dout.channel_sum    = s1_sum_s1;
			dout.pixels_counted = s1_cnt_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_move) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			m_data_q <= dout;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s_axis_tready)
		else $error("item taken during clear pass");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		is_start |=> clearing_q)
		else $error("start transaction did not begin a clear pass");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_free) |-> !s_axis_tready)
		else $error("item taken while a read result is stalled");

endmodule

`default_nettype wire
